FILE: src/mts_pkg.sv
// package for the multilevel thread scheduler: sizes, codes and shared types
// no dependencies
`timescale 1ns / 1ps

package mts_pkg;

  localparam int MaxThreads = 16;
  localparam int NumLevels  = 3;
  localparam int NumReasons = 8;

  localparam int TidW = $clog2(MaxThreads);
  localparam int PtrW = TidW + 1;
  localparam int LvlW = 2;
  localparam int RsnW = 3;

  localparam logic [PtrW-1:0] Nil = PtrW'(MaxThreads);

  typedef enum logic [2:0] {
    OP_ADMIT  = 3'd0,
    OP_SELECT = 3'd1,
    OP_RAN    = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_WAKE   = 3'd4,
    OP_KILL   = 3'd5,
    OP_SETLVL = 3'd6,
    OP_BAD    = 3'd7
  } op_e;

  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_EXEC    = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;

  localparam logic [1:0] ERR_OK  = 2'd0;
  localparam logic [1:0] ERR_ARG = 2'd1;
  localparam logic [1:0] ERR_UNK = 2'd2;

  localparam logic [1:0] REG_BONUS = 2'd0;
  localparam logic [1:0] REG_MALUS = 2'd1;
  localparam logic [1:0] REG_DLVL  = 2'd2;

  // list walker request and answer
  typedef struct packed {
    logic            start;
    logic [PtrW-1:0] head;
    logic [TidW-1:0] target;
  } walk_req_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [PtrW-1:0] prev;
  } walk_rsp_t;

endpackage

FILE: src/mts_walker.sv
// list walker: follows next links from a head until a target thread or the end
// depends on mts_pkg; reads the next-link table through a port of the top level
`timescale 1ns / 1ps

module mts_walker import mts_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  walk_req_t       req_i,
  output logic [TidW-1:0] rd_idx_o,
  input  logic [PtrW-1:0] rd_next_i,
  output walk_rsp_t       rsp_o
);

  logic            busy_q, busy_d;
  logic [PtrW-1:0] cur_q, cur_d, prev_q, prev_d;
  logic [TidW-1:0] tgt_q, tgt_d;
  logic            hit, atend;

  assign rd_idx_o = cur_q[TidW-1:0];
  assign atend    = cur_q[PtrW-1];
  assign hit      = !atend && (cur_q[TidW-1:0] == tgt_q);

  always_comb begin
    busy_d = busy_q;
    cur_d  = cur_q;
    prev_d = prev_q;
    tgt_d  = tgt_q;
    rsp_o  = '0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cur_d  = req_i.head;
      prev_d = Nil;
      tgt_d  = req_i.target;
    end else if (busy_q) begin
      if (atend || hit) begin
        busy_d      = 1'b0;
        rsp_o.done  = 1'b1;
        rsp_o.found = hit;
        rsp_o.prev  = prev_q;
      end else begin
        // one link per cycle
        prev_d = cur_q;
        cur_d  = rd_next_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    prev_q <= prev_d;
    tgt_q  <= tgt_d;
  end

endmodule

FILE: src/multilevel_thread_scheduler.sv
// multilevel thread scheduler top level: thread table, queues, sequencer
// depends on mts_pkg and mts_walker
//
//  channel | signals                                        | direction
//  in      | in_valid_i in_stall_o op_i thread_id_i ...      | word in
//  out     | out_valid_o out_stall_i chosen_thread_o idle_o  | word out
//  cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i  | register write
//
// select and rejected words go from the exec state straight to the done state; an admit also passes the append state
// a removal walks its list at one link per cycle, then fixes the links in the fix state
// worst case: a kill of a blocked thread tries each reason stack in turn
// a ran that promotes and then demotes walks two queues
// reset empties every queue and marks every thread slot free at once
// in_stall_o is high while an operation runs or its result waits
`timescale 1ns / 1ps

module multilevel_thread_scheduler import mts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [3:0]  thread_id_i,
  input  logic [2:0]  reason_i,
  input  logic [31:0] cpu_time_i,
  input  logic [1:0]  new_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  chosen_thread_o,
  output logic        idle_o,
  output logic [1:0]  error_code_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_EXEC   = 10'b0000000010,
    S_RMWALK = 10'b0000000100,
    S_RMFIX  = 10'b0000001000,
    S_AFTER  = 10'b0000010000,
    S_APPEND = 10'b0000100000,
    S_ADJ    = 10'b0001000000,
    S_PUSH   = 10'b0010000000,
    S_KILLB  = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_e;

  // what follows a removal
  typedef enum logic [2:0] {
    N_NONE   = 3'd0,
    N_APPEND = 3'd1,
    N_PUSH   = 3'd2,
    N_WAKE   = 3'd3,
    N_KILL   = 3'd4,
    N_ADJ    = 3'd5
  } next_e;

  state_e state_q, state_d;
  next_e  nxt_q, nxt_d;

  logic [MaxThreads-1:0] valid_q;
  logic [LvlW-1:0]  lvl_q  [MaxThreads];
  logic [1:0]       stat_q [MaxThreads];
  logic [31:0]      time_q [MaxThreads];
  logic [PtrW-1:0]  next_q [MaxThreads];
  logic [PtrW-1:0]  rhead_q [NumLevels];
  logic [PtrW-1:0]  rtail_q [NumLevels];
  logic [PtrW-1:0]  bhead_q [NumReasons];

  logic [31:0] bonus_q, malus_q;
  logic [1:0]  dlvl_q;

  logic [2:0]      op_q;
  logic [TidW-1:0] tid_q;
  logic [RsnW-1:0] rsn_q;
  logic [31:0]     dt_q;
  logic [LvlW-1:0] nl_q;
  logic [LvlW-1:0] lvl_w_q;   // level the walk runs on
  logic [LvlW-1:0] dest_q;    // level to append to
  logic [LvlW-1:0] mv_lvl_q;  // target of a pending move
  logic            bwalk_q;   // walk on a blocked stack
  logic            found_q;
  logic [PtrW-1:0] prev_q;
  logic [3:0]      ch_q;
  logic            idl_q;
  logic [1:0]      err_q;
  logic            ovld_q;

  walk_req_t       wreq;
  walk_rsp_t       wrsp;
  logic [TidW-1:0] wrd_idx;

  mts_walker u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (wreq),
    .rd_idx_o  (wrd_idx),
    .rd_next_i (next_q[wrd_idx]),
    .rsp_o     (wrsp)
  );

  logic accept;
  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE) || ovld_q;
  assign cfg_ready_o = (state_q == S_IDLE) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign chosen_thread_o = ch_q;
  assign idle_o      = idl_q;
  assign error_code_o = err_q;

  logic [32:0] tsum;
  logic [31:0] tsat;
  logic        tvalid;
  logic [LvlW-1:0] cur_lvl;
  logic [1:0]  cur_st;
  assign tvalid  = valid_q[tid_q];
  assign cur_lvl = lvl_q[tid_q];
  assign cur_st  = stat_q[tid_q];
  assign tsum    = {1'b0, time_q[tid_q]} + {1'b0, dt_q};
  assign tsat    = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

  // head of the most urgent non-empty level
  logic            sel_any;
  logic [TidW-1:0] sel_tid;
  always_comb begin
    sel_any = 1'b0;
    sel_tid = '0;
    for (int i = 0; i < NumLevels; i++) begin
      if (!sel_any && !rhead_q[i][PtrW-1]) begin
        sel_any = 1'b1;
        sel_tid = rhead_q[i][TidW-1:0];
      end
    end
  end

  // control sequencer with the list and valid writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      nxt_q   <= N_NONE;
      ovld_q  <= 1'b0;
      valid_q <= '0;
      bonus_q <= '0;
      malus_q <= 32'd1000;
      dlvl_q  <= 2'd1;
      for (int i = 0; i < NumLevels; i++) begin
        rhead_q[i] <= Nil;
        rtail_q[i] <= Nil;
      end
      for (int i = 0; i < NumReasons; i++) bhead_q[i] <= Nil;
    end else begin
      state_q <= state_d;
      nxt_q   <= nxt_d;
      if (out_valid_o && !out_stall_i) ovld_q <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          REG_BONUS: bonus_q <= cfg_data_i;
          REG_MALUS: malus_q <= cfg_data_i;
          REG_DLVL:  dlvl_q  <= cfg_data_i[1:0];
          default: ;
        endcase
      end
      unique case (state_q)
        S_EXEC: begin
          if (op_e'(op_q) == OP_ADMIT && !tvalid) valid_q[tid_q] <= 1'b1;
        end
        S_RMFIX: if (found_q) begin
          if (prev_q[PtrW-1]) begin
            if (bwalk_q) bhead_q[rsn_q] <= next_q[tid_q];
            else rhead_q[lvl_w_q] <= next_q[tid_q];
          end else begin
            next_q[prev_q[TidW-1:0]] <= next_q[tid_q];
          end
          if (!bwalk_q && rtail_q[lvl_w_q] == PtrW'(tid_q)) rtail_q[lvl_w_q] <= prev_q;
          next_q[tid_q] <= Nil;
        end
        S_APPEND: begin
          next_q[tid_q] <= Nil;
          if (rhead_q[dest_q][PtrW-1]) rhead_q[dest_q] <= PtrW'(tid_q);
          else next_q[rtail_q[dest_q][TidW-1:0]] <= PtrW'(tid_q);
          rtail_q[dest_q] <= PtrW'(tid_q);
        end
        S_PUSH: begin
          next_q[tid_q]  <= bhead_q[rsn_q];
          bhead_q[rsn_q] <= PtrW'(tid_q);
        end
        S_DONE: ovld_q <= 1'b1;
        default: ;
      endcase
      if (state_q == S_AFTER && nxt_q == N_KILL && (found_q || !bwalk_q ||
          rsn_q == RsnW'(NumReasons - 1))) begin
        valid_q[tid_q] <= 1'b0;
        next_q[tid_q]  <= Nil;
      end
    end
  end

  // payload and per-entry data
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      tid_q <= thread_id_i;
      rsn_q <= reason_i;
      dt_q  <= cpu_time_i;
      nl_q  <= new_level_i;
      err_q <= ERR_OK;
      ch_q  <= '0;
      idl_q <= 1'b0;
    end
    if (wrsp.done) begin
      found_q <= wrsp.found;
      prev_q  <= wrsp.prev;
    end
    unique case (state_q)
      S_EXEC: begin
        unique case (op_e'(op_q))
          OP_ADMIT: begin
            if (tvalid) err_q <= ERR_ARG;
            else begin
              lvl_q[tid_q]  <= (dlvl_q >= LvlW'(NumLevels)) ? LvlW'(NumLevels - 1) : dlvl_q;
              dest_q        <= (dlvl_q >= LvlW'(NumLevels)) ? LvlW'(NumLevels - 1) : dlvl_q;
              stat_q[tid_q] <= ST_READY;
              time_q[tid_q] <= '0;
            end
          end
          OP_SELECT: begin
            idl_q <= !sel_any;
            if (sel_any) begin
              ch_q            <= sel_tid;
              stat_q[sel_tid] <= ST_EXEC;
            end
          end
          OP_RAN: begin
            if (!tvalid) err_q <= ERR_UNK;
            else time_q[tid_q] <= tsat;
          end
          OP_SLEEP: if (!tvalid || cur_st == ST_BLOCKED) err_q <= ERR_ARG;
          OP_WAKE: if (!tvalid || cur_st != ST_BLOCKED) err_q <= ERR_ARG;
          OP_KILL: if (!tvalid) err_q <= ERR_UNK;
          OP_SETLVL: begin
            if (!tvalid) err_q <= ERR_UNK;
            else if (nl_q >= LvlW'(NumLevels)) err_q <= ERR_ARG;
            // a blocked thread only takes the level, used at wake
            else if (cur_st == ST_BLOCKED) lvl_q[tid_q] <= nl_q;
          end
          default: err_q <= ERR_ARG;
        endcase
        bwalk_q <= (op_e'(op_q) == OP_WAKE) || (op_e'(op_q) == OP_KILL && cur_st == ST_BLOCKED);
        lvl_w_q <= cur_lvl;
        if (op_e'(op_q) == OP_KILL) rsn_q <= '0;
      end
      S_AFTER: begin
        if (nxt_q == N_WAKE && !found_q) err_q <= ERR_ARG;
        if (nxt_q == N_WAKE) dest_q <= cur_lvl;
        if (nxt_q == N_ADJ || nxt_q == N_APPEND) begin
          dest_q       <= mv_lvl_q;
          lvl_q[tid_q] <= mv_lvl_q;
        end
        if (nxt_q == N_KILL && bwalk_q && !found_q && rsn_q != RsnW'(NumReasons - 1))
          rsn_q <= rsn_q + 1'b1;
      end
      S_ADJ: begin
        // one move at a time: promote, then demote
        stat_q[tid_q] <= ST_READY;
        lvl_w_q       <= cur_lvl;
      end
      S_APPEND: if (op_e'(op_q) == OP_WAKE) stat_q[tid_q] <= ST_READY;
      S_PUSH: stat_q[tid_q] <= ST_BLOCKED;
      default: ;
    endcase
  end

  // ran level adjustment bookkeeping
  logic adj_step_q;
  logic prom, dem;
  assign prom = (time_q[tid_q] <= bonus_q) && (cur_lvl != '0);
  assign dem  = (time_q[tid_q] >= malus_q) && (cur_lvl < LvlW'(NumLevels - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adj_step_q <= 1'b0;
    end else if (state_q == S_EXEC) begin
      adj_step_q <= 1'b0;
    end else if (state_q == S_ADJ) begin
      adj_step_q <= 1'b1;
    end
  end

  logic [LvlW-1:0] adj_lvl;
  assign adj_lvl = (!adj_step_q && prom) ? cur_lvl - 1'b1 : cur_lvl + 1'b1;

  // move target for an adjustment or a set level
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) mv_lvl_q <= nl_q;
    else if (state_q == S_ADJ) mv_lvl_q <= adj_lvl;
  end

  always_comb begin
    state_d = state_q;
    nxt_d   = nxt_q;
    wreq    = '0;
    wreq.target = tid_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_DONE;
        nxt_d   = N_NONE;
        unique case (op_e'(op_q))
          OP_ADMIT: if (!tvalid) state_d = S_APPEND;
          OP_RAN: if (tvalid && cur_st == ST_EXEC) state_d = S_ADJ;
          OP_SLEEP: if (tvalid && cur_st != ST_BLOCKED) begin
            wreq.start = 1'b1;
            wreq.head  = rhead_q[cur_lvl];
            nxt_d      = N_PUSH;
            state_d    = S_RMWALK;
          end
          OP_WAKE: if (tvalid && cur_st == ST_BLOCKED) begin
            wreq.start = 1'b1;
            wreq.head  = bhead_q[rsn_q];
            nxt_d      = N_WAKE;
            state_d    = S_RMWALK;
          end
          OP_KILL: if (tvalid) begin
            wreq.start = 1'b1;
            wreq.head  = (cur_st == ST_BLOCKED) ? bhead_q[0] : rhead_q[cur_lvl];
            nxt_d      = N_KILL;
            state_d    = S_RMWALK;
          end
          OP_SETLVL: if (tvalid && nl_q < LvlW'(NumLevels)) begin
            state_d = S_AFTER;
            nxt_d   = N_NONE;
            if (cur_st != ST_BLOCKED) begin
              wreq.start = 1'b1;
              wreq.head  = rhead_q[cur_lvl];
              nxt_d      = N_APPEND;
              state_d    = S_RMWALK;
            end
          end
          default: ;
        endcase
      end
      S_RMWALK: if (wrsp.done) state_d = S_RMFIX;
      S_RMFIX: state_d = S_AFTER;
      S_AFTER: begin
        state_d = S_DONE;
        unique case (nxt_q)
          N_PUSH:   state_d = S_PUSH;
          N_WAKE:   if (found_q) state_d = S_APPEND;
          N_APPEND: if (found_q) state_d = S_APPEND;
          N_ADJ:    state_d = found_q ? S_APPEND : S_ADJ;
          N_KILL:   if (bwalk_q && !found_q && rsn_q != RsnW'(NumReasons - 1))
                      state_d = S_KILLB;
          default:  ;
        endcase
      end
      S_KILLB: begin
        wreq.start = 1'b1;
        wreq.head  = bhead_q[rsn_q];
        state_d    = S_RMWALK;
      end
      S_ADJ: begin
        if (!adj_step_q && prom) begin
          // promote; the demote test follows on the new level
          wreq.start = 1'b1; wreq.head = rhead_q[cur_lvl];
          nxt_d = N_ADJ; state_d = S_RMWALK;
        end else if (dem) begin
          wreq.start = 1'b1; wreq.head = rhead_q[cur_lvl];
          nxt_d = N_APPEND; state_d = S_RMWALK;
        end else state_d = S_DONE;
      end
      S_APPEND: state_d = (nxt_q == N_ADJ) ? S_ADJ : S_DONE;
      S_PUSH: state_d = S_DONE;
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> in_stall_o)
    else $error("input taken while a result waits");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC) else $error("accepted word not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |=> out_valid_o) else $error("result lost");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wrsp.done |-> state_q == S_RMWALK) else $error("walk ended outside a walk");

endmodule
